/* hdl/brb_pkg.sv */
// Package for the byte ring buffer: transfer structs, opcodes, size codes,
// sequencer states and a helper function. No dependencies.
package brb_pkg;

  localparam int unsigned LenW         = 9;
  localparam int unsigned DataW        = 32;
  localparam int unsigned DepthDefault = 256;
  localparam int unsigned LenReset     = 256;

  localparam logic       OpWrite = 1'b0;
  localparam logic       OpRead  = 1'b1;

  localparam logic [1:0] Size1 = 2'd0;
  localparam logic [1:0] Size2 = 2'd1;

  typedef struct packed {
    logic             op;
    logic [1:0]       size_code;
    logic [DataW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [DataW-1:0] read_data;
    logic [LenW-1:0]  fill_level;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StWrite,
    StRead,
    StReadLast
  } state_e;

  // size code to byte count; any code other than Size1 and Size2 means four bytes
  function automatic logic [2:0] num_bytes(input logic [1:0] size_code);
    logic [2:0] n;
    case (size_code)
      Size1:   n = 3'd1;
      Size2:   n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

/* hdl/brb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/byte_ring_buffer_overwrite.sv */
// Byte ring buffer, overwrite-oldest on full, one byte per cycle through brb_ram.
// Depends on brb_pkg and brb_ram.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-------------------------------------
//   request  | start_i, busy_o, req_i   | transfer when start_i && !busy_o
//   result   | done_o, res_o            | one-cycle strobe, cannot be held off
//   config   | cfg_we_i, cfg_wdata_i    | written when cfg_we_i, idle only
//
// A write of N bytes (N = 1, 2, 4) does one RAM write per byte in StWrite; a read
// steps StRead per byte, then StReadLast for the registered RAM read. Result
// strobes the cycle after the last step. A read lacking data answers the cycle
// after transfer. Reset empties the buffer with length min(256, DEPTH); RAM
// contents are not cleared. busy_o is high while a transfer is sequenced.
module byte_ring_buffer_overwrite #(
  parameter int unsigned DEPTH = brb_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  brb_pkg::req_t               req_i,
  output logic                        done_o,
  output brb_pkg::rsp_t               res_o,
  input  logic                        cfg_we_i,
  input  logic [brb_pkg::LenW-1:0]    cfg_wdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = brb_pkg::LenW;
  localparam int unsigned CW = (AW > LW) ? AW + 1 : LW + 1;
  localparam int unsigned LenRst =
    (DEPTH < brb_pkg::LenReset) ? DEPTH : brb_pkg::LenReset;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] pos,
                                        input logic [LW-1:0] len);
    logic [CW-1:0] nxt;
    nxt = CW'(pos) + CW'(1);
    if (nxt >= CW'(len)) begin
      return '0;
    end
    return AW'(nxt);
  endfunction

  brb_pkg::state_e state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [AW-1:0]   wr_pos_q, wr_pos_d;
  logic [AW-1:0]   rd_pos_q, rd_pos_d;
  logic [LW-1:0]   fill_q, fill_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      col_q, col_d;
  logic            rvld_q, rvld_d;
  logic [31:0]     data_q, data_d;
  logic [31:0]     acc_q, acc_d;
  logic            done_q, done_d;
  brb_pkg::rsp_t   rsp_q, rsp_d;

  logic            accept;
  logic [2:0]      nb;
  logic            rd_fail;
  logic            ram_we;
  logic [7:0]      ram_rdata;

  assign accept  = start_i && !busy_o;
  assign nb      = brb_pkg::num_bytes(req_i.size_code);
  assign rd_fail = (req_i.op == brb_pkg::OpRead) && (fill_q < LW'(nb));

  brb_ram #(
    .Width(8),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_pos_q),
    .wdata_i(data_q[7:0]),
    .raddr_i(rd_pos_q),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brb_pkg::StIdle: begin
        if (accept && !rd_fail) begin
          state_d = (req_i.op == brb_pkg::OpWrite) ? brb_pkg::StWrite : brb_pkg::StRead;
        end
      end
      brb_pkg::StWrite: begin
        if (cnt_q == 2'd0) begin
          state_d = brb_pkg::StIdle;
        end
      end
      brb_pkg::StRead: begin
        if (cnt_q == 2'd0) begin
          state_d = brb_pkg::StReadLast;
        end
      end
      brb_pkg::StReadLast: state_d = brb_pkg::StIdle;
      default:             state_d = brb_pkg::StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_d    = len_q;
    wr_pos_d = wr_pos_q;
    rd_pos_d = rd_pos_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    rvld_d   = 1'b0;
    data_d   = data_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    ram_we   = 1'b0;
    busy_o   = (state_q != brb_pkg::StIdle);

    case (state_q)
      brb_pkg::StIdle: begin
        if (cfg_we_i) begin
          if (cfg_wdata_i == '0) begin
            len_d = LW'(1);
          end else if (CW'(cfg_wdata_i) > CW'(DEPTH)) begin
            len_d = LW'(DEPTH);
          end else begin
            len_d = cfg_wdata_i;
          end
          wr_pos_d = '0;
          rd_pos_d = '0;
          fill_d   = '0;
        end
        if (accept) begin
          data_d = req_i.write_data;
          acc_d  = '0;
          cnt_d  = 2'(nb - 3'd1);
          col_d  = '0;
          if (rd_fail) begin
            done_d           = 1'b1;
            rsp_d.ok         = 1'b0;
            rsp_d.read_data  = '0;
            rsp_d.fill_level = fill_q;
          end
        end
      end
      brb_pkg::StWrite: begin
        ram_we   = 1'b1;
        data_d   = data_q >> 8;
        wr_pos_d = adv(wr_pos_q, len_q);
        if (fill_q == len_q) begin
          rd_pos_d = adv(rd_pos_q, len_q);  // full: drop oldest
        end else begin
          fill_d = fill_q + LW'(1);
        end
        cnt_d = cnt_q - 2'd1;
        if (cnt_q == 2'd0) begin
          done_d           = 1'b1;
          rsp_d.ok         = 1'b1;
          rsp_d.read_data  = '0;
          rsp_d.fill_level = fill_d;
        end
      end
      brb_pkg::StRead: begin
        rvld_d   = 1'b1;
        rd_pos_d = adv(rd_pos_q, len_q);
        fill_d   = fill_q - LW'(1);
        cnt_d    = cnt_q - 2'd1;
        if (rvld_q) begin
          acc_d[col_q*8 +: 8] = ram_rdata;
          col_d = col_q + 2'd1;
        end
      end
      brb_pkg::StReadLast: begin
        acc_d[col_q*8 +: 8] = ram_rdata;
        done_d           = 1'b1;
        rsp_d.ok         = 1'b1;
        rsp_d.read_data  = acc_d;
        rsp_d.fill_level = fill_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= brb_pkg::StIdle;
      len_q    <= LW'(LenRst);
      wr_pos_q <= '0;
      rd_pos_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      col_q    <= '0;
      rvld_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      wr_pos_q <= wr_pos_d;
      rd_pos_q <= rd_pos_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      rvld_q   <= rvld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    acc_q  <= acc_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign res_o  = rsp_q;

`ifndef SYNTH
  a_fill_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("fill count above buffer length");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(wr_pos_q) < CW'(len_q)) && (CW'(rd_pos_q) < CW'(len_q)))
    else $error("position beyond buffer length");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.ok |-> res_o.read_data == '0)
    else $error("failed read returned data");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) || $past(start_i))
    else $error("result without a transfer");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0)
    else $error("zero buffer length");
`endif

endmodule

/* bench/brb_response_checker.sv */
`timescale 1ns / 100ps
// Response checker for byte_ring_buffer_overwrite: keeps its own copy of the ring,
// predicts each response on request transfer and compares on done. Depends on brb_pkg.
module brb_response_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  brb_pkg::req_t            req_i,
  input  logic                     done_i,
  input  brb_pkg::rsp_t            res_i,
  input  logic                     cfg_we_i,
  input  logic [brb_pkg::LenW-1:0] cfg_wdata_i,
  output int                       pending_o,
  output int                       errors_o,
  output int                       writes_o,
  output int                       reads_o,
  output int                       refused_o,
  output int                       overwrites_o,
  output int                       lengths_o
);

  logic [7:0]    ring_bytes [256];
  int unsigned   wr_pos, rd_pos, held, slots;
  int            errors, writes, reads, refused, overwrites, lengths;
  brb_pkg::rsp_t expected_responses [$];
  brb_pkg::rsp_t predicted, wanted;

  initial begin
    pending_o    = 0;
    errors_o     = 0;
    writes_o     = 0;
    reads_o      = 0;
    refused_o    = 0;
    overwrites_o = 0;
    lengths_o    = 0;
    errors       = 0;
    writes       = 0;
    reads        = 0;
    refused      = 0;
    overwrites   = 0;
    lengths      = 0;
  end

  function automatic int unsigned clamp_slots(input logic [brb_pkg::LenW-1:0] v);
    if (v == '0) return 1;
    if (v > 9'd256) return 256;
    return 32'(v);
  endfunction

  function automatic int unsigned next_slot(input int unsigned pos);
    return (pos + 1 >= slots) ? 0 : pos + 1;
  endfunction

  task automatic predict_response(input brb_pkg::req_t r, output brb_pkg::rsp_t e);
    int unsigned nb;
    e = '0;
    e.ok = 1'b1;
    case (r.size_code)
      brb_pkg::Size1: nb = 1;
      brb_pkg::Size2: nb = 2;
      default:        nb = 4;
    endcase
    if (r.op == brb_pkg::OpWrite) begin
      writes++;
      for (int i = 0; i < nb; i++) begin
        ring_bytes[wr_pos] = r.write_data[8*i +: 8];
        wr_pos = next_slot(wr_pos);
        held++;
        if (held > slots) begin
          held = slots;
          rd_pos = next_slot(rd_pos);
          overwrites++;
        end
      end
    end else if (held < nb) begin
      e.ok = 1'b0;
      refused++;
    end else begin
      reads++;
      for (int i = 0; i < nb; i++) begin
        e.read_data[8*i +: 8] = ring_bytes[rd_pos];
        rd_pos = next_slot(rd_pos);
        held--;
      end
    end
    e.fill_level = held[brb_pkg::LenW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots  = clamp_slots(brb_pkg::LenReset[brb_pkg::LenW-1:0]);
      wr_pos = 0;
      rd_pos = 0;
      held   = 0;
      expected_responses.delete();
    end else begin
      if (cfg_we_i) begin
        slots  = clamp_slots(cfg_wdata_i);
        wr_pos = 0;
        rd_pos = 0;
        held   = 0;
        lengths++;
      end
      if (done_i) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response: expected nothing, actual ok=%0b data=%h fill=%0d",
                   $time, res_i.ok, res_i.read_data, res_i.fill_level);
          errors++;
        end else begin
          wanted = expected_responses.pop_front();
          if (res_i.ok !== wanted.ok) begin
            $display("%0t: ok expected %0b, actual %0b", $time, wanted.ok, res_i.ok);
            errors++;
          end
          if (res_i.read_data !== wanted.read_data) begin
            $display("%0t: read_data expected %h, actual %h", $time, wanted.read_data,
                     res_i.read_data);
            errors++;
          end
          if (res_i.fill_level !== wanted.fill_level) begin
            $display("%0t: fill_level expected %0d, actual %0d", $time, wanted.fill_level,
                     res_i.fill_level);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_response(req_i, predicted);
        expected_responses.push_back(predicted);
      end
      pending_o    <= expected_responses.size();
      errors_o     <= errors;
      writes_o     <= writes;
      reads_o      <= reads;
      refused_o    <= refused;
      overwrites_o <= overwrites;
      lengths_o    <= lengths;
    end
  end

endmodule

/* bench/byte_ring_buffer_overwrite_test.sv */
`timescale 1ns / 100ps
// Top of the byte ring buffer bench: clock, reset, request and length stimulus.
// Depends on brb_pkg, byte_ring_buffer_overwrite and brb_response_checker.
module byte_ring_buffer_overwrite_test;

  localparam logic [1:0] SizeFour  = 2'd2;
  localparam logic [1:0] SizeSpare = 2'd3;
  localparam int         Phases    = 12;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  brb_pkg::req_t            req_i = '0;
  logic                     done_o;
  brb_pkg::rsp_t            res_o;
  logic                     cfg_we_i = 1'b0;
  logic [brb_pkg::LenW-1:0] cfg_wdata_i = '0;

  int pending, errors, writes, reads, refused, overwrites, lengths;

  int unsigned phase_slots [Phases] = '{2, 511, 4, 256, 1, 300, 7, 128, 5, 255, 16, 0};

  always #5 clk_i = ~clk_i;

  byte_ring_buffer_overwrite DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  brb_response_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .errors_o     (errors),
    .writes_o     (writes),
    .reads_o      (reads),
    .refused_o    (refused),
    .overwrites_o (overwrites),
    .lengths_o    (lengths)
  );

  // waits for the edge that takes the transfer; start then stays high unless a random gap follows (never when steady)
  task automatic issue(input logic op, input logic [1:0] size, input logic [31:0] data,
                       input bit steady);
    int gap;
    start_i <= 1'b1;
    req_i   <= '{op: op, size_code: size, write_data: data};
    do @(posedge clk_i); while (busy_o);
    if (!steady && $urandom_range(3) == 0) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  task automatic set_length(input logic [brb_pkg::LenW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned items, wr_pct;
    bit          steady;
    logic        op;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty buffer, all sizes refused; then mixed sizes round trip
    issue(brb_pkg::OpRead, brb_pkg::Size1, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, SizeFour, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, SizeSpare, 32'h0, 1'b0);
    issue(brb_pkg::OpWrite, brb_pkg::Size1, 32'hFFFF_FFFF, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size1, 32'h0, 1'b0);
    issue(brb_pkg::OpWrite, brb_pkg::Size2, 32'h0000_A55A, 1'b0);
    issue(brb_pkg::OpWrite, SizeFour, 32'hFFFF_FFFF, 1'b0);
    issue(brb_pkg::OpWrite, SizeSpare, 32'h0000_0000, 1'b0);
    issue(brb_pkg::OpWrite, SizeFour, 32'h8000_0001, 1'b0);
    issue(brb_pkg::OpRead, SizeFour, 32'hFFFF_FFFF, 1'b0);
    issue(brb_pkg::OpRead, SizeSpare, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, SizeFour, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size1, 32'h0, 1'b0);
    drain();

    // zero length means one slot: four-byte write keeps only its top byte
    set_length(9'd0);
    issue(brb_pkg::OpWrite, SizeFour, 32'h1234_5678, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size1, 32'h0, 1'b0);
    drain();

    set_length(9'd3);
    issue(brb_pkg::OpWrite, SizeFour, 32'hDEAD_BEEF, 1'b0);
    issue(brb_pkg::OpRead, SizeFour, 32'h0, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    issue(brb_pkg::OpWrite, brb_pkg::Size1, 32'h0000_005A, 1'b0);
    issue(brb_pkg::OpRead, brb_pkg::Size2, 32'h0, 1'b0);
    drain();

    for (int p = 0; p < Phases; p++) begin
      set_length(phase_slots[p][brb_pkg::LenW-1:0]);
      steady = (p == Phases - 1);
      items  = steady ? 150 : 85;
      wr_pct = $urandom_range(30, 80);
      for (int n = 0; n < items; n++) begin
        op = ($urandom_range(99) < wr_pct) ? brb_pkg::OpWrite : brb_pkg::OpRead;
        issue(op, 2'($urandom_range(3)), $urandom(), steady);
        if (!steady && $urandom_range(39) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("%0d writes, %0d reads with data, %0d reads refused, %0d bytes overwritten",
             writes, reads, refused, overwrites);
    $display("%0d buffer length settings, including zero and above depth", lengths);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
